FILE: rtl/copy_request_sort_coalesce_assert.svh
// assertion macros for the copy request coalescer
`ifndef COPY_REQUEST_SORT_COALESCE_ASSERT_SVH
`define COPY_REQUEST_SORT_COALESCE_ASSERT_SVH

// property that must hold on every clock edge outside reset
`define CRSC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define CRSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: rtl/crsc_pkg.sv
`default_nettype none
package crsc_pkg;
  localparam int LEN_BITS = 32;
  localparam int SUM_BITS = 38;
  localparam int TOT_BITS = 7;
  localparam int AWAY_BITS = 6;

  // controller phases
  localparam logic [1:0] ST_FILL  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // control from the sequencer into the chain
  typedef struct packed {
    logic insert;
    logic shift;
    logic rotate;
  } chain_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/copy_request_sort_coalesce.sv
`default_nettype none
// copy request sorter and coalescer
// input channel: valid/ready with one copy request word per handshake;
//   last_request closes the batch
// output channel: valid/ready with one merged region word per handshake,
//   carrying the batch totals (regions_total, merged_away, overflow)
// requests enter a row of MAX_PENDING sorting cells, one word a cycle while filling, each
//   landing at its ordered place (source key, then destination key, arrival
//   order kept for equal keys); words beyond capacity are dropped and flagged
// on last the row first rotates once round past the head to count the regions,
//   then drains from the head one cell a cycle, unless a stalled region word holds
//   it, to emit them; input is taken again once the final region word is taken
// the merge compares start plus running length exactly, with no wrap
// a stalled receiver holds the region word and the drain waits with it
// reset empties the row and clears the count and the dropped flag (not the overflow output)
module copy_request_sort_coalesce #(
  parameter int MAX_PENDING = 64,
  parameter int HEAP_BITS = 8,
  parameter int OFFSET_BITS = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [HEAP_BITS-1:0]        src_heap,
  input  wire  [OFFSET_BITS-1:0]      src_offset,
  input  wire  [HEAP_BITS-1:0]        dst_heap,
  input  wire  [OFFSET_BITS-1:0]      dst_offset,
  input  wire  [31:0]                 length_bytes,
  input  wire                         last_request,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [HEAP_BITS-1:0]        out_src_heap,
  output logic [OFFSET_BITS-1:0]      out_src_offset,
  output logic [HEAP_BITS-1:0]        out_dst_heap,
  output logic [OFFSET_BITS-1:0]      out_dst_offset,
  output logic [37:0]                 out_length,
  output logic                        last_region,
  output logic [6:0]                  regions_total,
  output logic [5:0]                  merged_away,
  output logic                        overflow
);
  localparam int KB = HEAP_BITS + OFFSET_BITS;
  localparam int LB = crsc_pkg::LEN_BITS;
  localparam int SB = crsc_pkg::SUM_BITS;
  localparam int CB = $clog2(MAX_PENDING + 1);
  localparam int EB = (OFFSET_BITS > SB ? OFFSET_BITS : SB) + 1;

  logic [1:0] state;
  logic [CB-1:0] count;
  logic dropped;
  logic [6:0] regions;
  logic pass2;
  crsc_pkg::chain_ctl_t ctl;

  logic [MAX_PENDING-1:0] cv, cg;
  logic [KB-1:0] cs [MAX_PENDING];
  logic [KB-1:0] cd [MAX_PENDING];
  logic [LB-1:0] cl [MAX_PENDING];

  wire [KB-1:0] nskey = {src_heap, src_offset};
  wire [KB-1:0] ndkey = {dst_heap, dst_offset};
  wire full = (count == CB'(MAX_PENDING));
  wire acc = in_valid && in_ready;

  genvar g;
  generate
    for (g = 0; g < MAX_PENDING; g++) begin : g_cell
      localparam int GP = (g == 0) ? 0 : g - 1;
      localparam int GN = (g == MAX_PENDING - 1) ? g : g + 1;
      crsc_cell #(.KEY_BITS(KB), .LEN_BITS(LB)) u_cell (
        .clk, .rst, .ctl,
        .new_skey(nskey), .new_dkey(ndkey), .new_len(length_bytes),
        .prev_valid(g == 0 ? 1'b1 : cv[GP]),
        .prev_goes(g == 0 ? 1'b0 : cg[GP]),
        .prev_skey(g == 0 ? nskey : cs[GP]),
        .prev_dkey(g == 0 ? ndkey : cd[GP]),
        .prev_len(g == 0 ? length_bytes : cl[GP]),
        .next_valid(g == MAX_PENDING-1 ? 1'b0 : cv[GN]),
        .next_skey(cs[GN]),
        .next_dkey(cd[GN]),
        .next_len(cl[GN]),
        .head_skey(cs[0]), .head_dkey(cd[0]), .head_len(cl[0]),
        .valid(cv[g]), .goes(cg[g]), .skey(cs[g]), .dkey(cd[g]), .len(cl[g])
      );
    end
  endgenerate

  // running region
  logic          rv;
  logic [KB-1:0] rs, rd;
  logic [SB-1:0] rl;

  wire [EB-1:0] send = EB'(rs[OFFSET_BITS-1:0]) + EB'(rl);
  wire [EB-1:0] dend = EB'(rd[OFFSET_BITS-1:0]) + EB'(rl);
  wire join_ok = rv && cv[0]
    && rs[KB-1:OFFSET_BITS] == cs[0][KB-1:OFFSET_BITS]
    && rd[KB-1:OFFSET_BITS] == cd[0][KB-1:OFFSET_BITS]
    && send == EB'(cs[0][OFFSET_BITS-1:0])
    && dend == EB'(cd[0][OFFSET_BITS-1:0]);
  // region closes when the head cannot join it
  wire closes = rv && !join_ok;
  wire step = (state == crsc_pkg::ST_DRAIN) && (!closes || !out_valid || out_ready);

  // first pass: count regions while the row rotates once round past the head
  logic [CB-1:0] idx;
  logic [KB-1:0] ps, pd;
  logic [SB-1:0] pl;
  logic pv;
  wire [EB-1:0] pse = EB'(ps[OFFSET_BITS-1:0]) + EB'(pl);
  wire [EB-1:0] pde = EB'(pd[OFFSET_BITS-1:0]) + EB'(pl);
  wire pj = pv && ps[KB-1:OFFSET_BITS] == cs[0][KB-1:OFFSET_BITS]
    && pd[KB-1:OFFSET_BITS] == cd[0][KB-1:OFFSET_BITS]
    && pse == EB'(cs[0][OFFSET_BITS-1:0]) && pde == EB'(cd[0][OFFSET_BITS-1:0]);

  assign in_ready = (state == crsc_pkg::ST_FILL);
  assign ctl.insert = acc && !full;
  assign ctl.shift = step && cv[0] && pass2;
  assign ctl.rotate = (state == crsc_pkg::ST_COUNT) && (idx != count);

  // region word valid: set when a region closes, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && closes) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crsc_pkg::ST_FILL;
      count <= '0;
      dropped <= 1'b0;
      rv <= 1'b0;
      pv <= 1'b0;
      pass2 <= 1'b0;
      regions <= '0;
      idx <= '0;
    end else begin
      case (state)
        crsc_pkg::ST_FILL: begin
          if (acc) begin
            if (full) dropped <= 1'b1;
            else count <= count + 1'b1;
            if (last_request) begin
              state <= crsc_pkg::ST_COUNT;
              idx <= '0;
              pv <= 1'b0;
              regions <= '0;
            end
          end
        end
        crsc_pkg::ST_COUNT: begin
          if (idx == count) begin
            state <= crsc_pkg::ST_DRAIN;
            pass2 <= 1'b1;
            rv <= 1'b0;
          end else begin
            if (pj) begin
              pl <= pl + SB'(cl[0]);
            end else begin
              regions <= regions + 7'd1;
              ps <= cs[0];
              pd <= cd[0];
              pl <= SB'(cl[0]);
              pv <= 1'b1;
            end
            idx <= idx + 1'b1;
          end
        end
        crsc_pkg::ST_DRAIN: begin
          if (step) begin
            if (closes) begin
              out_src_heap <= rs[KB-1:OFFSET_BITS];
              out_src_offset <= rs[OFFSET_BITS-1:0];
              out_dst_heap <= rd[KB-1:OFFSET_BITS];
              out_dst_offset <= rd[OFFSET_BITS-1:0];
              out_length <= rl;
              last_region <= !cv[0];
              regions_total <= regions;
              merged_away <= 6'(7'(count) - regions);
              overflow <= dropped;
            end
            if (cv[0]) begin
              if (join_ok) begin
                rl <= rl + SB'(cl[0]);
              end else begin
                rs <= cs[0];
                rd <= cd[0];
                rl <= SB'(cl[0]);
              end
              rv <= 1'b1;
            end else begin
              rv <= 1'b0;
              if (!rv) state <= crsc_pkg::ST_EMIT;
            end
          end
        end
        crsc_pkg::ST_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= crsc_pkg::ST_FILL;
            count <= '0;
            dropped <= 1'b0;
            pass2 <= 1'b0;
          end
        end
        default: state <= crsc_pkg::ST_FILL;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/crsc_cell.sv
`default_nettype none
// one sorter cell: holds an entry, inserts in order, shifts or rotates towards the head
module crsc_cell #(
  parameter int KEY_BITS = 40,
  parameter int LEN_BITS = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  crsc_pkg::chain_ctl_t  ctl,
  input  wire  [KEY_BITS-1:0]   new_skey,
  input  wire  [KEY_BITS-1:0]   new_dkey,
  input  wire  [LEN_BITS-1:0]   new_len,
  // neighbour on the head side (for insertion push)
  input  wire                   prev_valid,
  input  wire                   prev_goes,
  input  wire  [KEY_BITS-1:0]   prev_skey,
  input  wire  [KEY_BITS-1:0]   prev_dkey,
  input  wire  [LEN_BITS-1:0]   prev_len,
  // neighbour on the tail side (for drain shift)
  input  wire                   next_valid,
  input  wire  [KEY_BITS-1:0]   next_skey,
  input  wire  [KEY_BITS-1:0]   next_dkey,
  input  wire  [LEN_BITS-1:0]   next_len,
  // head entry, taken by the last held cell while rotating
  input  wire  [KEY_BITS-1:0]   head_skey,
  input  wire  [KEY_BITS-1:0]   head_dkey,
  input  wire  [LEN_BITS-1:0]   head_len,
  output logic                  valid,
  output logic                  goes,
  output logic [KEY_BITS-1:0]   skey,
  output logic [KEY_BITS-1:0]   dkey,
  output logic [LEN_BITS-1:0]   len
);
  // new word goes before this entry when strictly smaller (keeps arrival order)
  assign goes = valid && ((new_skey < skey) || (new_skey == skey && new_dkey < dkey));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= next_valid;
    end else if (ctl.insert) begin
      valid <= valid || prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      skey <= next_skey;
      dkey <= next_dkey;
      len  <= next_len;
    end else if (ctl.rotate) begin
      if (next_valid) begin
        skey <= next_skey;
        dkey <= next_dkey;
        len  <= next_len;
      end else begin
        skey <= head_skey;
        dkey <= head_dkey;
        len  <= head_len;
      end
    end else if (ctl.insert) begin
      if (prev_goes) begin
        skey <= prev_skey;
        dkey <= prev_dkey;
        len  <= prev_len;
      end else if (goes || (!valid && prev_valid)) begin
        skey <= new_skey;
        dkey <= new_dkey;
        len  <= new_len;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/crsc_checker.sv
`default_nettype none
`include "copy_request_sort_coalesce_assert.svh"
// port-level checks on the coalescer
module crsc_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       last_region,
  input wire [6:0] regions_total,
  input wire       overflow
);
  `CRSC_ASSERT(a_no_overlap, clk, rst, !(in_ready && out_valid && !last_region))
  `CRSC_ASSERT(a_total_nonzero, clk, rst, !out_valid || regions_total != 7'd0)
  `CRSC_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid)
  `CRSC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `CRSC_ASSERT_NEXT(a_flag_hold, clk, rst, out_valid && !out_ready, $stable(overflow))
endmodule

bind copy_request_sort_coalesce crsc_checker u_crsc_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .last_region, .regions_total, .overflow
);
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  // one copy request word
  typedef struct packed {
    logic [7:0]  sh;
    logic [31:0] so;
    logic [7:0]  dh;
    logic [31:0] dof;
    logic [31:0] len;
    logic        last;
  } copy_req_t;

  // one merged region word
  typedef struct packed {
    logic [7:0]  sh;
    logic [31:0] so;
    logic [7:0]  dh;
    logic [31:0] dof;
    logic [37:0] len;
    logic        last;
    logic [6:0]  total;
    logic [5:0]  away;
    logic        ovf;
  } region_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0]  src_heap = '0;
  logic [31:0] src_offset = '0;
  logic [7:0]  dst_heap = '0;
  logic [31:0] dst_offset = '0;
  logic [31:0] length_bytes = '0;
  logic        last_request = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0]  out_src_heap;
  logic [31:0] out_src_offset;
  logic [7:0]  out_dst_heap;
  logic [31:0] out_dst_offset;
  logic [37:0] out_length;
  logic        last_region;
  logic [6:0]  regions_total;
  logic [5:0]  merged_away;
  logic        overflow;

  always #4 clk = ~clk;

  copy_request_sort_coalesce u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .src_heap(src_heap), .src_offset(src_offset),
    .dst_heap(dst_heap), .dst_offset(dst_offset),
    .length_bytes(length_bytes), .last_request(last_request),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_src_heap(out_src_heap), .out_src_offset(out_src_offset),
    .out_dst_heap(out_dst_heap), .out_dst_offset(out_dst_offset),
    .out_length(out_length), .last_region(last_region),
    .regions_total(regions_total), .merged_away(merged_away),
    .overflow(overflow)
  );

  copy_req_t pending_words[$];
  region_t   expected_regions[$];
  int        fails = 0;
  bit        hold_sender = 1'b0;

  // batch store, mirrors the block's pending requests
  copy_req_t batch_store[DEPTH];
  int        batch_count = 0;
  bit        batch_dropped = 1'b0;

  // heap and offset concatenated give the sort key
  function automatic bit sorts_ahead(copy_req_t a, copy_req_t b);
    if ({a.sh, a.so} != {b.sh, b.so})
      return {a.sh, a.so} < {b.sh, b.so};
    return {a.dh, a.dof} < {b.dh, b.dof};
  endfunction

  // store a word; on last, sort stably, coalesce and queue the regions
  task automatic accept_request(copy_req_t w);
    copy_req_t ord[DEPTH];
    region_t   regs[$];
    region_t   cur;
    copy_req_t v;
    int j;
    if (batch_count < DEPTH) begin
      batch_store[batch_count] = w;
      batch_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (!w.last) return;
    for (int i = 0; i < batch_count; i++) begin
      v = batch_store[i];
      j = i;
      while (j > 0 && sorts_ahead(v, ord[j-1])) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
    cur = '0;
    cur.sh = ord[0].sh; cur.so = ord[0].so;
    cur.dh = ord[0].dh; cur.dof = ord[0].dof;
    cur.len = {6'd0, ord[0].len};
    for (int i = 1; i < batch_count; i++) begin
      // exact comparison, no wrap at the offset width
      if (cur.sh == ord[i].sh && cur.dh == ord[i].dh &&
          {7'd0, cur.so} + {1'b0, cur.len} == {7'd0, ord[i].so} &&
          {7'd0, cur.dof} + {1'b0, cur.len} == {7'd0, ord[i].dof}) begin
        cur.len = cur.len + {6'd0, ord[i].len};
      end else begin
        regs = {regs, cur};
        cur = '0;
        cur.sh = ord[i].sh; cur.so = ord[i].so;
        cur.dh = ord[i].dh; cur.dof = ord[i].dof;
        cur.len = {6'd0, ord[i].len};
      end
    end
    regs = {regs, cur};
    foreach (regs[k]) begin
      regs[k].last  = (k == regs.size() - 1);
      regs[k].total = 7'(regs.size());
      regs[k].away  = 6'(batch_count - regs.size());
      regs[k].ovf   = batch_dropped;
      expected_regions = {expected_regions, regs[k]};
    end
    batch_count = 0;
    batch_dropped = 1'b0;
  endtask

  // driver: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) void'(pending_words.pop_front());
      if (in_valid && !in_ready) begin
        // hold word until taken
      end else if (hold_sender || pending_words.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else begin
        copy_req_t nw;
        nw = pending_words[0];
        in_valid <= 1'b1;
        {src_heap, src_offset, dst_heap, dst_offset, length_bytes, last_request} <= nw;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // predictor runs on every accepted request word
  always @(posedge clk)
    if (!rst && in_valid && in_ready)
      accept_request({src_heap, src_offset, dst_heap, dst_offset, length_bytes,
                      last_request});

  // receiver stall pattern: stretches of always ready, of mostly ready and of mostly stalled
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 300;
      if (stall_phase < 100) out_ready <= 1'b1;
      else if (stall_phase < 200) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 3) == 0);
    end
  end

  // monitor: compare each region word with the oldest expectation
  always @(posedge clk) begin
    region_t got, exp_r;
    if (!rst && out_valid && out_ready) begin
      got = {out_src_heap, out_src_offset, out_dst_heap, out_dst_offset, out_length,
             last_region, regions_total, merged_away, overflow};
      if (expected_regions.size() == 0) begin
        $display("%0t: unexpected region word %h", $realtime, got);
        fails++;
      end else begin
        exp_r = expected_regions.pop_front();
        if (got !== exp_r) begin
          $display("%0t: region mismatch expected %h actual %h", $realtime, exp_r, got);
          fails++;
        end
      end
    end
  end

  function automatic copy_req_t rand_request(bit last);
    copy_req_t w;
    w.sh = 8'($urandom); w.so = $urandom; w.dh = 8'($urandom); w.dof = $urandom;
    w.len = $urandom; w.last = last;
    return w;
  endfunction

  // contiguous chain with a shared start, shuffled, some words broken
  task automatic queue_chain_batch(int n);
    copy_req_t ws[$];
    copy_req_t w;
    logic [31:0] so, dof;
    logic [7:0] sh, dh;
    sh = 8'($urandom_range(0, 3)); dh = 8'($urandom_range(0, 3));
    so = ($urandom_range(0, 5) == 0) ? 32'hffff_ff00 : 32'($urandom_range(0, 4096));
    dof = 32'($urandom_range(0, 4096));
    for (int i = 0; i < n; i++) begin
      w = '0;
      w.sh = sh; w.so = so; w.dh = dh; w.dof = dof;
      w.len = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(1, 200));
      case ($urandom_range(0, 9))
        0: w = rand_request(1'b0);
        1: w.dof = w.dof + 32'd1;
        2: w.dh = w.dh + 8'd1;
        default: ;
      endcase
      ws = {ws, w};
      so = so + w.len; dof = dof + w.len;
    end
    ws.shuffle();
    ws[n-1].last = 1'b1;
    foreach (ws[k]) pending_words = {pending_words, ws[k]};
  endtask

  initial begin
    int n;
    copy_req_t w;
    // directed: extremes, single word batch, zero length, equal keys, wrap
    w = '1; pending_words = {pending_words, w};
    w = '0; w.last = 1'b1; pending_words = {pending_words, w};
    w = '0; w.sh = 8'hff; w.so = 32'hffff_fff0; w.len = 32'h10;
    pending_words = {pending_words, w};
    w = '0; w.len = 5; pending_words = {pending_words, w};
    w = '0; w.so = 5; w.dof = 5; pending_words = {pending_words, w};
    w = '0; w.so = 5; w.dof = 5; w.len = 3; pending_words = {pending_words, w};
    w = '0; w.so = 8; w.dof = 8; w.len = 32'hffff_ffff; pending_words = {pending_words, w};
    w = '0; w.sh = 8'hff; w.len = 1; w.last = 1'b1; pending_words = {pending_words, w};
    // overflow: a full store plus extra words, last one dropped too
    for (int i = 0; i < DEPTH + 3; i++) begin
      w = rand_request(i == DEPTH + 2);
      pending_words = {pending_words, w};
    end
    // exactly full batch of one coalescing chain
    queue_chain_batch(DEPTH);
    wait (!rst);
    wait (pending_words.size() == 0 && !in_valid && expected_regions.size() == 0);
    // sender pauses once every region has come
    hold_sender = 1'b1;
    repeat (20) @(posedge clk);
    hold_sender = 1'b0;
    for (int b = 0; b < 20; b++) begin
      n = ($urandom_range(0, 12) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < n; i++) pending_words = {pending_words, rand_request(i == n - 1)};
      end else begin
        queue_chain_batch(n);
      end
    end
    wait (pending_words.size() == 0 && !in_valid && expected_regions.size() == 0);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

FILE: copy_request_sort_coalesce.f
+incdir+rtl
rtl/crsc_pkg.sv
rtl/crsc_cell.sv
rtl/copy_request_sort_coalesce.sv
rtl/crsc_checker.sv
tb/testbench.sv
